// ===== hw/rtl/fctab_pkg.sv =====
// Shared types, codes and constants of the FAT cluster table engine.
`timescale 1ns / 1ps

package fctab_pkg;

	// Table geometry
	localparam int TABLE_ENTRIES = 4096;
	localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
	localparam int DATA_W        = 32;
	localparam int LIMIT_W       = 13;
	localparam int CLUSTER_W     = 12;
	localparam int OP_W          = 3;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = LIMIT_W;
	localparam logic [CFG_IDX_W-1:0] CFG_FAT_TYPE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT = 1'd1;
	localparam logic [LIMIT_W-1:0]   LIMIT_RESET     = 13'd4096;
	localparam logic [LIMIT_W-1:0]   TABLE_LIM       = LIMIT_W'(TABLE_ENTRIES);

	// Entry formats; any other code acts as thirty-two-bit
	localparam logic [1:0] FAT12 = 2'd0;
	localparam logic [1:0] FAT16 = 2'd1;

	localparam logic [DATA_W-1:0] MASK12   = 32'h0000_0FFF;
	localparam logic [DATA_W-1:0] MASK16   = 32'h0000_FFFF;
	localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [DATA_W-1:0] END12    = 32'h0000_0FF0;
	localparam logic [DATA_W-1:0] END16    = 32'h0000_FFF0;
	localparam logic [DATA_W-1:0] END32    = 32'hFFFF_FFF0;

	// Free search starts past the reserved entries
	localparam logic [DATA_W-1:0] FIND_FIRST = 32'd3;

	// Operation codes
	localparam logic [OP_W-1:0] OP_READ  = 3'd0;
	localparam logic [OP_W-1:0] OP_LINK  = 3'd1;
	localparam logic [OP_W-1:0] OP_ALLOC = 3'd2;
	localparam logic [OP_W-1:0] OP_FIND  = 3'd3;
	localparam logic [OP_W-1:0] OP_CHAIN = 3'd4;
	localparam logic [OP_W-1:0] OP_RUN   = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic [CLUSTER_W-1:0] cluster;
		logic [DATA_W-1:0]    link_value;
	} in_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              limit_hit;
	} out_t;

	// Result source chosen by the controller
	typedef enum logic [2:0] {
		RES_ZERO,
		RES_ONES,
		RES_ENTRY,
		RES_CUR,
		RES_COUNT,
		RES_COUNT_INC
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     wr;
		logic     rd_cur;
		logic     rd_next;
		logic     fin;
		logic     hit;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            in_range;
		logic            entry_zero;
		logic            walk_stop;
		logic            next_out;
	} stat_t;

endpackage

// ===== hw/rtl/fctab_dp.sv =====
// Datapath: configuration registers, table memory, walk cursor and result register.
`timescale 1ns / 1ps

module fctab_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fctab_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fctab_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  fctab_pkg::in_t                     in_data,
	input  fctab_pkg::cmd_t                    cmd,
	output fctab_pkg::stat_t                   stat,
	output fctab_pkg::out_t                    out_data
);

	logic [1:0]                         fat_type_q;
	logic [fctab_pkg::LIMIT_W-1:0]      entry_limit_q;
	logic [fctab_pkg::LIMIT_W-1:0]      lim;

	logic [fctab_pkg::OP_W-1:0]         op_q;
	logic [fctab_pkg::DATA_W-1:0]       lv_q;
	logic [fctab_pkg::DATA_W-1:0]       cur_q;
	logic [fctab_pkg::LIMIT_W-1:0]      links_q;
	logic [fctab_pkg::DATA_W-1:0]       rdata_q;
	logic [fctab_pkg::DATA_W-1:0]       fat_table_q [fctab_pkg::TABLE_ENTRIES];
	fctab_pkg::out_t                    out_q;

	logic [fctab_pkg::DATA_W-1:0]       mask;
	logic [fctab_pkg::DATA_W-1:0]       end_mark;
	logic [fctab_pkg::DATA_W-1:0]       masked;
	logic [fctab_pkg::DATA_W-1:0]       entry;
	logic [fctab_pkg::DATA_W-1:0]       lim_ext;
	logic [fctab_pkg::DATA_W-1:0]       cur_plus;
	logic [fctab_pkg::DATA_W-1:0]       next_idx;
	logic [fctab_pkg::LIMIT_W-1:0]      links_inc;
	logic [fctab_pkg::LIMIT_W-1:0]      links_inc2;
	logic [fctab_pkg::ADDR_W-1:0]       rd_addr;
	logic [fctab_pkg::DATA_W-1:0]       wr_data;
	logic [fctab_pkg::DATA_W-1:0]       res_val;
	logic                               is_find;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fat_type_q    <= fctab_pkg::FAT12;
			entry_limit_q <= fctab_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fctab_pkg::CFG_FAT_TYPE:    fat_type_q    <= cfg_data[1:0];
				fctab_pkg::CFG_ENTRY_LIMIT: entry_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Usable table size
	assign lim     = (entry_limit_q > fctab_pkg::TABLE_LIM) ? fctab_pkg::TABLE_LIM
		: entry_limit_q;
	assign lim_ext = fctab_pkg::DATA_W'(lim);

	// Entry format
	always_comb begin
		case (fat_type_q)
			fctab_pkg::FAT12: begin
				mask     = fctab_pkg::MASK12;
				end_mark = fctab_pkg::END12;
			end
			fctab_pkg::FAT16: begin
				mask     = fctab_pkg::MASK16;
				end_mark = fctab_pkg::END16;
			end
			default: begin
				mask     = fctab_pkg::ALL_ONES;
				end_mark = fctab_pkg::END32;
			end
		endcase
	end

	// Decode of the entry just read: end-of-chain marks fold to all ones
	assign masked = rdata_q & mask;
	assign entry  = (masked >= end_mark) ? fctab_pkg::ALL_ONES : masked;

	// Next position of the search or the walk
	assign is_find    = (op_q == fctab_pkg::OP_FIND);
	assign cur_plus   = cur_q + 32'd1;
	assign next_idx   = is_find ? cur_plus : entry;
	assign links_inc  = links_q + 13'd1;
	assign links_inc2 = links_q + 13'd2;

	// Status toward the controller
	always_comb begin
		stat.op         = op_q;
		stat.in_range   = (cur_q < lim_ext);
		stat.entry_zero = (entry == '0);
		stat.walk_stop  = (entry == fctab_pkg::ALL_ONES)
			|| ((op_q == fctab_pkg::OP_RUN) && (entry != cur_plus));
		stat.next_out   = (next_idx >= lim_ext) || (!is_find && (links_inc >= lim));
	end

	// Item and cursor registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= in_data.op;
			lv_q    <= in_data.link_value;
			cur_q   <= (in_data.op == fctab_pkg::OP_FIND) ? fctab_pkg::FIND_FIRST
				: fctab_pkg::DATA_W'(in_data.cluster);
			links_q <= '0;
		end else if (cmd.rd_next) begin
			cur_q   <= next_idx;
			links_q <= links_inc;
		end
	end

	// Table memory: one write port, one registered read port
	assign rd_addr = cmd.rd_next ? next_idx[fctab_pkg::ADDR_W-1:0]
		: cur_q[fctab_pkg::ADDR_W-1:0];
	assign wr_data = (op_q == fctab_pkg::OP_ALLOC) ? mask : (lv_q & mask);

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			fat_table_q[cur_q[fctab_pkg::ADDR_W-1:0]] <= wr_data;
		end
		if (cmd.rd_cur || cmd.rd_next) begin
			rdata_q <= fat_table_q[rd_addr];
		end
	end

	// Result selection
	always_comb begin
		case (cmd.res_sel)
			fctab_pkg::RES_ZERO:      res_val = '0;
			fctab_pkg::RES_ONES:      res_val = fctab_pkg::ALL_ONES;
			fctab_pkg::RES_ENTRY:     res_val = entry;
			fctab_pkg::RES_CUR:       res_val = cur_q;
			fctab_pkg::RES_COUNT:     res_val = fctab_pkg::DATA_W'(links_inc);
			fctab_pkg::RES_COUNT_INC: res_val = fctab_pkg::DATA_W'(links_inc2);
			default:                  res_val = '0;
		endcase
	end

	// Output register, loaded only when the output side is free
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_q.value     <= res_val;
			out_q.limit_hit <= cmd.hit;
		end
	end

	assign out_data = out_q;

endmodule

// ===== hw/rtl/fctab_ctrl.sv =====
// Controller: sequences each operation and owns the channel handshakes.
`timescale 1ns / 1ps

module fctab_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  fctab_pkg::stat_t  stat,
	output fctab_pkg::cmd_t   cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_EVAL
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Finish an item: only when the output register can take it
	function automatic fctab_pkg::cmd_t finish(input fctab_pkg::cmd_t c,
		input fctab_pkg::res_sel_t sel, input logic hit);
		fctab_pkg::cmd_t r;
		r         = c;
		r.fin     = 1'b1;
		r.res_sel = sel;
		r.hit     = hit;
		return r;
	endfunction

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				case (stat.op)
					fctab_pkg::OP_LINK, fctab_pkg::OP_ALLOC: begin
						if (out_free) begin
							cmd     = finish(cmd, fctab_pkg::RES_ZERO, !stat.in_range);
							cmd.wr  = stat.in_range;
							state_d = S_IDLE;
						end
					end
					fctab_pkg::OP_READ, fctab_pkg::OP_FIND: begin
						if (stat.in_range) begin
							cmd.rd_cur = 1'b1;
							state_d    = S_EVAL;
						end else if (out_free) begin
							cmd     = finish(cmd, fctab_pkg::RES_ONES, 1'b1);
							state_d = S_IDLE;
						end
					end
					fctab_pkg::OP_CHAIN, fctab_pkg::OP_RUN: begin
						if (stat.in_range) begin
							cmd.rd_cur = 1'b1;
							state_d    = S_EVAL;
						end else if (out_free) begin
							cmd     = finish(cmd, fctab_pkg::RES_COUNT, 1'b1);
							state_d = S_IDLE;
						end
					end
					default: begin
						if (out_free) begin
							cmd     = finish(cmd, fctab_pkg::RES_ZERO, 1'b0);
							state_d = S_IDLE;
						end
					end
				endcase
			end
			S_EVAL: begin
				case (stat.op)
					fctab_pkg::OP_READ: begin
						if (out_free) begin
							cmd     = finish(cmd, fctab_pkg::RES_ENTRY, 1'b0);
							state_d = S_IDLE;
						end
					end
					fctab_pkg::OP_FIND: begin
						if (stat.entry_zero) begin
							if (out_free) begin
								cmd     = finish(cmd, fctab_pkg::RES_CUR, 1'b0);
								state_d = S_IDLE;
							end
						end else if (stat.next_out) begin
							if (out_free) begin
								cmd     = finish(cmd, fctab_pkg::RES_ONES, 1'b1);
								state_d = S_IDLE;
							end
						end else begin
							cmd.rd_next = 1'b1;
						end
					end
					fctab_pkg::OP_CHAIN, fctab_pkg::OP_RUN: begin
						if (stat.walk_stop) begin
							if (out_free) begin
								cmd     = finish(cmd, fctab_pkg::RES_COUNT, 1'b0);
								state_d = S_IDLE;
							end
						end else if (stat.next_out) begin
							// the link that leaves the range still counts
							if (out_free) begin
								cmd     = finish(cmd, fctab_pkg::RES_COUNT_INC, 1'b1);
								state_d = S_IDLE;
							end
						end else begin
							cmd.rd_next = 1'b1;
						end
					end
					default: begin
						if (out_free) begin
							cmd     = finish(cmd, fctab_pkg::RES_ZERO, 1'b0);
							state_d = S_IDLE;
						end
					end
				endcase
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/fat_cluster_table_engine_top.sv =====
// Top level of the FAT cluster table engine.
`timescale 1ns / 1ps

// One operation at a time. Link and allocate finish in the start state; a
// read in range issues its table read in the start state and finishes in
// the evaluate state. Find free, chain length and contiguous run then step
// through the table one entry at a time in the evaluate state, since each
// step's next address comes from the single registered read port of the
// table memory. A result waits in the output register while the next item
// is taken and worked on; an item finishes only once that register is free,
// so a stalled output holds it back. The table holds no defined contents
// after reset: every entry a search or walk touches must have been written.
// Configuration writes are taken at once and belong only in idle periods.

module fat_cluster_table_engine_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  fctab_pkg::in_t                    in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output fctab_pkg::out_t                   out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fctab_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fctab_pkg::CFG_DATA_W-1:0]  cfg_data
);

	fctab_pkg::cmd_t  cmd;
	fctab_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	fctab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fctab_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);

endmodule

// ===== hw/rtl/fctab_checker.sv =====
// Port-level checks of the FAT cluster table engine, bound to the top level.
`timescale 1ns / 1ps

module fctab_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input fctab_pkg::out_t out_data
);

	// One item at a time: an input beat makes the block busy
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in progress");

	// A fresh result frees the input side in the same cycle
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result shown while the block is still busy");

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result dropped or changed");

endmodule

bind fat_cluster_table_engine_top fctab_checker u_fctab_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== test/tb.sv =====
// Self-checking testbench for the FAT cluster table engine top level.
`timescale 1ns / 1ps

module tb;
	import fctab_pkg::*;

	// Entry format codes with no name in the package; code 3 behaves as 32-bit
	localparam logic [1:0] FAT32   = 2'd2;
	localparam logic [1:0] FAT_ALT = 2'd3;
	// Unused operation codes, accepted and answered with zero
	localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

	localparam int unsigned IDLE_GAP       = 8;
	localparam int unsigned DRAIN_CYCLES   = 20;
	localparam int unsigned WATCHDOG_LIMIT = 30000;
	localparam int unsigned REPORT_MAX     = 10;
	// Low part of the table that gets written; later limits stay inside it
	localparam int unsigned FILL_ENTRIES   = 256;

	typedef struct {
		in_t  item;
		out_t result;
	} check_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow copy of the table and registers
	logic [DATA_W-1:0] shadow_fat [TABLE_ENTRIES];
	logic [1:0] cur_fat_type = FAT12;
	logic [LIMIT_W-1:0] cur_limit = LIMIT_RESET;

	in_t pending_ops [$];
	check_entry_t expected_results [$];
	check_entry_t accepted_entry;
	check_entry_t chk;

	int unsigned items_queued = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned cfg_writes = 0;
	int unsigned limit_results = 0;
	int unsigned op_beats [8];
	int unsigned gap_left = 0;
	int unsigned hold_left = 0;
	int unsigned in_calm = 0;
	int unsigned out_calm = 0;

	fat_cluster_table_engine_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------- prediction

	function automatic logic [DATA_W-1:0] entry_mask();
		if (cur_fat_type == FAT12) return MASK12;
		if (cur_fat_type == FAT16) return MASK16;
		return ALL_ONES;
	endfunction

	function automatic logic [DATA_W-1:0] eoc_mark();
		if (cur_fat_type == FAT12) return END12;
		if (cur_fat_type == FAT16) return END16;
		return END32;
	endfunction

	function automatic int unsigned usable_entries();
		return (cur_limit < TABLE_LIM) ? cur_limit : TABLE_LIM;
	endfunction

	// Entry as seen through the current width; end-of-chain folds to all ones
	function automatic logic [DATA_W-1:0] entry_lookup(input int unsigned idx);
		logic [DATA_W-1:0] v;
		v = shadow_fat[idx] & entry_mask();
		return (v >= eoc_mark()) ? ALL_ONES : v;
	endfunction

	// Chain or contiguous-run length; hit set when the walk leaves the usable entries or reaches the link bound
	function automatic logic [DATA_W-1:0] walk_count(input logic [CLUSTER_W-1:0] start,
			input bit contig, output logic hit);
		int unsigned lim, cur, links;
		logic [DATA_W-1:0] count, nx;
		lim = usable_entries();
		count = 1;
		cur = start;
		links = 0;
		hit = 1'b0;
		while (1) begin
			if (cur >= lim || links >= lim) begin
				hit = 1'b1;
				break;
			end
			nx = entry_lookup(cur);
			if (nx == ALL_ONES) break;
			if (contig && nx != cur + 1) break;
			count++;
			links++;
			cur = nx;
		end
		return count;
	endfunction

	function automatic out_t fat_engine_predict(input in_t item);
		out_t r;
		int unsigned lim, i;
		logic h;
		lim = usable_entries();
		r.value = '0;
		r.limit_hit = 1'b0;
		case (item.op)
			OP_READ: begin
				if (item.cluster < lim) r.value = entry_lookup(item.cluster);
				else begin
					r.value = ALL_ONES;
					r.limit_hit = 1'b1;
				end
			end
			OP_LINK: begin
				if (item.cluster < lim) shadow_fat[item.cluster] = item.link_value & entry_mask();
				else r.limit_hit = 1'b1;
			end
			OP_ALLOC: begin
				if (item.cluster < lim) shadow_fat[item.cluster] = entry_mask();
				else r.limit_hit = 1'b1;
			end
			OP_FIND: begin
				i = FIND_FIRST;
				while (i < lim && entry_lookup(i) != '0) i++;
				if (i >= lim) begin
					r.value = ALL_ONES;
					r.limit_hit = 1'b1;
				end else r.value = i;
			end
			OP_CHAIN: begin
				r.value = walk_count(item.cluster, 1'b0, h);
				r.limit_hit = h;
			end
			OP_RUN: begin
				r.value = walk_count(item.cluster, 1'b1, h);
				r.limit_hit = h;
			end
			default: ;
		endcase
		return r;
	endfunction

	// Mostly short gaps, a few long ones, and now and then a stretch with none
	function automatic int unsigned draw_gap(inout int unsigned calm);
		int unsigned r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) calm = $urandom_range(20, 120);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ---------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				accepted_entry.item = in_data;
				accepted_entry.result = fat_engine_predict(in_data);
				expected_results.push_back(accepted_entry);
				op_beats[in_data.op]++;
				if (accepted_entry.result.limit_hit) limit_results++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					in_data <= pending_ops.pop_front();
					in_valid <= 1'b1;
					gap_left = draw_gap(in_calm);
				end else in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected result beat: value %h limit_hit %b",
							out_data.value, out_data.limit_hit);
				end else begin
					chk = expected_results.pop_front();
					if (out_data.value !== chk.result.value ||
							out_data.limit_hit !== chk.result.limit_hit) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$display("op %0d cluster %0d link %h:",
								chk.item.op, chk.item.cluster, chk.item.link_value);
							$display("  value exp %h got %h, limit_hit exp %b got %b",
								chk.result.value, out_data.value,
								chk.result.limit_hit, out_data.limit_hit);
						end
					end
				end
				hold_left = draw_gap(out_calm);
			end else if (hold_left > 0) hold_left--;
			out_ready <= (hold_left == 0);
		end
	end

	// ---------------------------------------------------------------- watchdog

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else quiet++;
		end
		$display("no beat on any channel for %0d cycles", WATCHDOG_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// ---------------------------------------------------------------- stimulus

	task automatic queue_op(input logic [OP_W-1:0] op, input logic [CLUSTER_W-1:0] cl,
			input logic [DATA_W-1:0] lv);
		in_t item;
		item.op = op;
		item.cluster = cl;
		item.link_value = lv;
		pending_ops.push_back(item);
		items_queued++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_FAT_TYPE) cur_fat_type = data[1:0];
		else cur_limit = data;
		cfg_writes++;
	endtask

	// Every result back, then an idle gap for the block to settle
	task automatic wait_quiet();
		while (results_seen != items_queued) @(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic set_phase(input logic [1:0] ftype, input logic [LIMIT_W-1:0] lim);
		write_reg(CFG_FAT_TYPE, CFG_DATA_W'(ftype));
		write_reg(CFG_ENTRY_LIMIT, lim);
	endtask

	// Single operation with random fields; entries 0..2 stay end-of-chain
	task automatic queue_noise(input int unsigned lim);
		logic [OP_W-1:0] op;
		logic [CLUSTER_W-1:0] cl;
		logic [DATA_W-1:0] lv;
		int unsigned r;
		op = $urandom_range(0, 7);
		if (lim <= 3 || $urandom_range(0, 9) < 2) cl = $urandom_range(0, TABLE_ENTRIES - 1);
		else cl = $urandom_range(3, lim - 1);
		if ((op == OP_LINK || op == OP_ALLOC) && cl < 3) cl = cl + 3;
		r = $urandom_range(0, 7);
		case (r)
			0: lv = '0;
			1: lv = ALL_ONES;
			2: lv = eoc_mark() - 1 + $urandom_range(0, 2);
			3, 4: lv = (lim > 0) ? $urandom_range(0, lim - 1) : $urandom();
			default: lv = $urandom();
		endcase
		queue_op(op, cl, lv);
	endtask

	// Build a chain, end it (now and then with a random link instead), then walk and read it
	task automatic queue_chain(input int unsigned lim);
		logic [CLUSTER_W-1:0] nodes [8];
		logic [DATA_W-1:0] junk;
		int unsigned n, k, j;
		bit contig, fresh;
		n = $urandom_range(1, (lim - 3 < 8) ? lim - 3 : 8);
		contig = $urandom_range(0, 1);
		junk = ~entry_mask();
		if (contig) begin
			nodes[0] = $urandom_range(3, lim - n);
			for (k = 1; k < n; k++) nodes[k] = nodes[0] + k;
		end else begin
			for (k = 0; k < n; k++) begin
				do begin
					nodes[k] = $urandom_range(3, lim - 1);
					fresh = 1'b1;
					for (j = 0; j < k; j++) if (nodes[j] == nodes[k]) fresh = 1'b0;
				end while (!fresh);
			end
		end
		// bits above the entry width must be dropped by the block
		for (k = 0; k + 1 < n; k++)
			queue_op(OP_LINK, nodes[k], ($urandom() & junk) | nodes[k + 1]);
		if ($urandom_range(0, 7) == 0) queue_op(OP_LINK, nodes[n - 1], $urandom());
		else queue_op(OP_ALLOC, nodes[n - 1], $urandom());
		queue_op(OP_CHAIN, nodes[0], $urandom());
		queue_op(OP_RUN, nodes[0], $urandom());
		k = $urandom_range(0, n - 1);
		queue_op(OP_READ, nodes[k], $urandom());
		if ($urandom_range(0, 1)) queue_op(OP_CHAIN, nodes[k], $urandom());
	endtask

	task automatic queue_random(input int unsigned count);
		int unsigned lim, stop;
		lim = usable_entries();
		stop = items_queued + count;
		while (items_queued < stop) begin
			if (lim >= 4 && $urandom_range(0, 9) < 7) queue_chain(lim);
			else queue_noise(lim);
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		int unsigned c;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Full-width format and an oversized limit while the low part of the
		// table is filled; its last entry stays free so a search ends inside it
		set_phase(FAT_ALT, 13'd8191);
		for (c = 0; c < FILL_ENTRIES; c++) begin
			if (c == FILL_ENTRIES - 1 || (c >= 3 && $urandom_range(0, 15) == 0))
				queue_op(OP_LINK, CLUSTER_W'(c), '0);
			else queue_op(OP_LINK, CLUSTER_W'(c), ALL_ONES);
		end
		wait_quiet();

		// Directed: marks, short chains, an escaping link, unused codes
		queue_op(OP_READ, 0, '0);
		queue_op(OP_LINK, 5, END32 - 1);
		queue_op(OP_READ, 5, '0);
		queue_op(OP_LINK, 5, END32);
		queue_op(OP_READ, 5, '0);
		queue_op(OP_LINK, 6, 7);
		queue_op(OP_LINK, 7, 8);
		queue_op(OP_ALLOC, 8, '0);
		queue_op(OP_CHAIN, 6, '0);
		queue_op(OP_RUN, 6, '0);
		queue_op(OP_LINK, 10, 20);
		queue_op(OP_ALLOC, 20, '0);
		queue_op(OP_RUN, 10, '0);
		queue_op(OP_LINK, 11, 32'h1234_5678);
		queue_op(OP_CHAIN, 11, '0);
		queue_op(OP_FIND, 0, '0);
		queue_op(OP_SPARE6, 12'hFFF, ALL_ONES);
		queue_op(OP_SPARE7, 0, '0);
		queue_op(OP_ALLOC, 12'hFFF, '0);
		wait_quiet();

		// Random work stays within the filled entries from here on
		write_reg(CFG_ENTRY_LIMIT, LIMIT_W'(FILL_ENTRIES));
		queue_random(150);
		wait_quiet();

		set_phase(FAT32, LIMIT_W'(FILL_ENTRIES));
		queue_random(100);
		wait_quiet();

		set_phase(FAT16, 13'd200);
		queue_random(100);
		wait_quiet();

		set_phase(FAT12, LIMIT_W'(FILL_ENTRIES));
		queue_random(150);
		wait_quiet();

		// Empty table: everything is out of range
		write_reg(CFG_ENTRY_LIMIT, 13'd0);
		queue_random(20);
		wait_quiet();

		// Only reserved entries usable: search never finds one
		write_reg(CFG_ENTRY_LIMIT, 13'd3);
		queue_random(20);
		wait_quiet();

		// Small table with a self loop that must stop after the link bound
		write_reg(CFG_ENTRY_LIMIT, 13'd16);
		queue_op(OP_LINK, 13, 13);
		queue_op(OP_CHAIN, 13, '0);
		queue_op(OP_RUN, 13, '0);
		queue_random(40);
		wait_quiet();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0d results never arrived", expected_results.size());
			mismatches += expected_results.size();
		end
		$display("%0d results: read %0d link %0d alloc %0d find %0d",
			results_seen, op_beats[OP_READ], op_beats[OP_LINK], op_beats[OP_ALLOC],
			op_beats[OP_FIND]);
		$display("  chain %0d run %0d unused %0d", op_beats[OP_CHAIN], op_beats[OP_RUN],
			op_beats[OP_SPARE6] + op_beats[OP_SPARE7]);
		$display("%0d register writes over formats 0-3 and limits 0-8191",
			cfg_writes);
		$display("%0d results flagged the limit; %0d mismatches",
			limit_results, mismatches);
		if (mismatches == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule
